@@ rtl/tgcs_pkg.sv @@
// shared constants and types of the text grid cursor and scroll block
package tgcs_pkg;

	localparam int MAX_COLS = 128;
	localparam int MAX_ROWS = 64;

	localparam int ACT_W    = 3;
	localparam int CODE_W   = 8;
	localparam int COL_W    = 8;
	localparam int ROW_W    = 6;
	localparam int CFG_COLS_W = 8;
	localparam int CFG_ROWS_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int CIDX_W = $clog2(MAX_COLS);
	localparam int ADDR_W = $clog2(MAX_COLS * MAX_ROWS);

	localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(80);
	localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(25);

	localparam logic [ACT_W-1:0] ACT_PUT  = ACT_W'(0);
	localparam logic [ACT_W-1:0] ACT_CR   = ACT_W'(1);
	localparam logic [ACT_W-1:0] ACT_LF   = ACT_W'(2);
	localparam logic [ACT_W-1:0] ACT_MOVE = ACT_W'(3);
	localparam logic [ACT_W-1:0] ACT_READ = ACT_W'(4);

	localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(1);

	typedef struct packed {
		logic capture;
		logic exec;
		logic sweep_all;
		logic sweep_row;
		logic write_put;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic scroll;
		logic is_put;
		logic all_last;
		logic row_last;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/tgcs_in_if.sv @@
// input item channel
interface tgcs_in_if;
	import tgcs_pkg::*;

	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [CODE_W-1:0] char_code;
	logic [COL_W-1:0]  target_col;
	logic [ROW_W-1:0]  target_row;

	modport source (output valid, action, char_code, target_col, target_row, input ready);
	modport sink (input valid, action, char_code, target_col, target_row, output ready);
endinterface

@@ rtl/tgcs_out_if.sv @@
// result item channel
interface tgcs_out_if;
	import tgcs_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] cell_char;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic              scrolled;

	modport source (output valid, cell_char, cursor_col, cursor_row, scrolled, input ready);
	modport sink (input valid, cell_char, cursor_col, cursor_row, scrolled, output ready);
endinterface

@@ rtl/tgcs_cfg_if.sv @@
// configuration write channel
interface tgcs_cfg_if;
	import tgcs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/tgcs_ctrl.sv @@
// sequencing state machine of the grid block
module tgcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tgcs_pkg::dp_stat_t stat,
	output tgcs_pkg::ctl_cmd_t cmd
);
	import tgcs_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_CLEAR,
		S_WRITE,
		S_RESULT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			case (state_q)
				S_INIT: begin
					if (stat.all_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= stat.scroll ? S_CLEAR : S_RESULT;
				end
				S_CLEAR: begin
					if (stat.row_last) state_q <= stat.is_put ? S_WRITE : S_RESULT;
				end
				S_WRITE: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.exec      = (state_q == S_EXEC);
		cmd.sweep_all = (state_q == S_INIT);
		cmd.sweep_row = (state_q == S_CLEAR);
		cmd.write_put = (state_q == S_WRITE);
		cmd.load_out  = (state_q == S_RESULT) && stat.out_free;
	end
endmodule

@@ rtl/tgcs_datapath.sv @@
// cursor, offset, cell store and result register of the grid block
module tgcs_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tgcs_pkg::ctl_cmd_t            cmd,
	output tgcs_pkg::dp_stat_t            stat,
	input  logic [tgcs_pkg::ACT_W-1:0]    in_action,
	input  logic [tgcs_pkg::CODE_W-1:0]   in_char_code,
	input  logic [tgcs_pkg::COL_W-1:0]    in_target_col,
	input  logic [tgcs_pkg::ROW_W-1:0]    in_target_row,
	input  logic                          cfg_we,
	input  logic [tgcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgcs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [tgcs_pkg::CODE_W-1:0]   out_cell_char,
	output logic [tgcs_pkg::COL_W-1:0]    out_cursor_col,
	output logic [tgcs_pkg::ROW_W-1:0]    out_cursor_row,
	output logic                          out_scrolled
);
	import tgcs_pkg::*;

	function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W:0] sum);
		logic [ROW_W:0] r;
		r = sum;
		if (r >= (ROW_W+1)'(MAX_ROWS)) r = r - (ROW_W+1)'(MAX_ROWS);
		return r[ROW_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
			input logic [CIDX_W-1:0] col);
		return ADDR_W'(prow) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
	endfunction

	logic [CODE_W-1:0] mem [MAX_COLS*MAX_ROWS];

	logic [CFG_COLS_W-1:0] cols_q;
	logic [CFG_ROWS_W-1:0] rows_q;
	logic [COL_W-1:0]      cur_col_q;
	logic [ROW_W-1:0]      cur_row_q;
	logic [ROW_W-1:0]      top_q;
	logic [ROW_W-1:0]      clr_row_q;
	logic [ADDR_W-1:0]     cnt_q;
	logic                  scrolled_q;
	logic                  rd_ok_q;
	logic [CODE_W-1:0]     rd_q;
	logic                  out_valid_q;

	logic [ACT_W-1:0]  act_q;
	logic [CODE_W-1:0] code_q;
	logic [COL_W-1:0]  tcol_q;
	logic [ROW_W-1:0]  trow_q;

	logic [COL_W-1:0]  w;
	logic [ROW_W:0]    h;
	logic [ROW_W-1:0]  hm1;
	logic [COL_W-1:0]  cc;
	logic [ROW_W-1:0]  cr;
	logic [ROW_W-1:0]  tr;
	logic              wrap;
	logic              do_lf;
	logic              at_bottom;
	logic              scroll;
	logic [ROW_W-1:0]  lf_row;
	logic [COL_W-1:0]  put_col;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;
	logic              put_we;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CODE_W-1:0] mem_wdata;
	logic              all_last;
	logic              row_last;

	// effective grid size
	always_comb begin
		if (cols_q == '0) w = COL_W'(1);
		else if (cols_q > CFG_COLS_W'(MAX_COLS)) w = COL_W'(MAX_COLS);
		else w = COL_W'(cols_q);
		if (rows_q == '0) h = (ROW_W+1)'(1);
		else if (rows_q > CFG_ROWS_W'(MAX_ROWS)) h = (ROW_W+1)'(MAX_ROWS);
		else h = (ROW_W+1)'(rows_q);
		hm1 = ROW_W'(h - (ROW_W+1)'(1));
	end

	// one step of the item on the clamped cursor
	always_comb begin
		cc        = (cur_col_q > w) ? w : cur_col_q;
		cr        = (cur_row_q > hm1) ? hm1 : cur_row_q;
		tr        = (trow_q > hm1) ? hm1 : trow_q;
		wrap      = (cc >= w);
		at_bottom = (cr == hm1);
		do_lf     = (act_q == ACT_LF) || ((act_q == ACT_PUT) && wrap);
		scroll    = do_lf && at_bottom;
		lf_row    = (do_lf && !at_bottom) ? cr + ROW_W'(1) : cr;
		put_col   = wrap ? '0 : cc;
		nxt_col   = cc;
		nxt_row   = cr;
		put_we    = 1'b0;
		rd_en     = 1'b0;
		case (act_q)
			ACT_PUT: begin
				nxt_row = lf_row;
				if (scroll) begin
					nxt_col = '0;
				end else begin
					nxt_col = put_col + COL_W'(1);
					put_we  = 1'b1;
				end
			end
			ACT_CR: begin
				nxt_col = '0;
			end
			ACT_LF: begin
				nxt_row = lf_row;
			end
			ACT_MOVE: begin
				nxt_row = tr;
				nxt_col = (tcol_q > w) ? w : tcol_q;
			end
			ACT_READ: begin
				rd_en = 1'b1;
			end
			default: begin
			end
		endcase
		rd_addr = cell_addr(wrap_row({1'b0, top_q} + {1'b0, tr}), tcol_q[CIDX_W-1:0]);
	end

	// single write port of the store
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		if (cmd.sweep_all) begin
			mem_we = 1'b1;
		end else if (cmd.sweep_row) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr(clr_row_q, cnt_q[CIDX_W-1:0]);
		end else if (cmd.exec && put_we) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr(wrap_row({1'b0, top_q} + {1'b0, lf_row}),
				put_col[CIDX_W-1:0]);
			mem_wdata = code_q;
		end else if (cmd.write_put) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr(wrap_row({1'b0, top_q} + {1'b0, cur_row_q}),
				cur_col_q[CIDX_W-1:0]);
			mem_wdata = code_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.exec && rd_en) rd_q <= mem[rd_addr];
	end

	assign all_last = (cnt_q == ADDR_W'(MAX_COLS*MAX_ROWS - 1));
	assign row_last = (cnt_q == ADDR_W'(MAX_COLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= COLS_RESET;
			rows_q      <= ROWS_RESET;
			cur_col_q   <= '0;
			cur_row_q   <= ROW_W'(ROWS_RESET - CFG_ROWS_W'(1));
			top_q       <= '0;
			cnt_q       <= '0;
			scrolled_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_COLS: cols_q <= cfg_data;
					CFG_ROWS: rows_q <= cfg_data[CFG_ROWS_W-1:0];
					default: begin
					end
				endcase
			end
			if ((cmd.sweep_all && all_last) || (cmd.sweep_row && row_last)) begin
				cnt_q <= '0;
			end else if (cmd.sweep_all || cmd.sweep_row) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			if (cmd.exec) begin
				cur_col_q  <= nxt_col;
				cur_row_q  <= nxt_row;
				scrolled_q <= scroll;
				if (scroll) top_q <= wrap_row({1'b0, top_q} + (ROW_W+1)'(1));
			end
			if (cmd.write_put) cur_col_q <= cur_col_q + COL_W'(1);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= in_action;
			code_q <= in_char_code;
			tcol_q <= in_target_col;
			trow_q <= in_target_row;
		end
		if (cmd.exec) begin
			clr_row_q <= wrap_row({1'b0, top_q} + h);
			rd_ok_q   <= (act_q == ACT_READ) && (tcol_q < w);
		end
		if (cmd.load_out) begin
			out_cell_char  <= rd_ok_q ? rd_q : '0;
			out_cursor_col <= cur_col_q;
			out_cursor_row <= cur_row_q;
			out_scrolled   <= scrolled_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		stat          = '0;
		stat.scroll   = scroll;
		stat.is_put   = (act_q == ACT_PUT);
		stat.all_last = all_last;
		stat.row_last = row_last;
		stat.out_free = !out_valid_q || out_ready;
	end
endmodule

@@ rtl/text_grid_cursor_scroll.sv @@
// top level of the text grid cursor and scroll block
// Character cell store of a text terminal (128 columns by 64 rows of bytes)
// with a cursor and a row rotation offset. After reset the block clears the
// whole store, one cell a cycle, and accepts no item in that time;
// configuration writes are taken at any time. An item then passes through
// accept, execute and load of the result register: put, carriage return,
// line feed, move and read all execute in the execute state on the single
// write and read port of the store. A line feed or wrapping put on the
// bottom row clears the new bottom row at one cell a cycle, and a put that
// scrolls then writes its character in a separate write state. The next
// item is accepted while the previous result waits in the output register.
module text_grid_cursor_scroll (
	input logic        clk,
	input logic        arst_n,
	tgcs_in_if.sink    in_ch,
	tgcs_out_if.source out_ch,
	tgcs_cfg_if.sink   cfg
);
	import tgcs_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg.ready = 1'b1;

	tgcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tgcs_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_action      (in_ch.action),
		.in_char_code   (in_ch.char_code),
		.in_target_col  (in_ch.target_col),
		.in_target_row  (in_ch.target_row),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.out_cell_char  (out_ch.cell_char),
		.out_cursor_col (out_ch.cursor_col),
		.out_cursor_row (out_ch.cursor_row),
		.out_scrolled   (out_ch.scrolled)
	);
endmodule

@@ test/tgcs_result_checker.sv @@
// checker that predicts every result of the text grid block from the observed items and compares
module tgcs_result_checker (
	input  logic clk,
	input  logic arst_n,
	tgcs_in_if   in_ch,
	tgcs_out_if  out_ch,
	tgcs_cfg_if  cfg,
	output int   results_owed,
	output int   mismatches
);
	import tgcs_pkg::*;

	typedef struct packed {
		logic [CODE_W-1:0] cell_char;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic              scrolled;
	} screen_result_t;

	logic [CODE_W-1:0]     cells [MAX_COLS*MAX_ROWS];
	logic [CFG_COLS_W-1:0] cols_reg;
	logic [CFG_ROWS_W-1:0] rows_reg;
	int                    top_off;
	int                    cur_col;
	int                    cur_row;
	screen_result_t        owed_q [$];

	function automatic int grid_width();
		int w;
		w = int'(cols_reg);
		if (w < 1) w = 1;
		if (w > MAX_COLS) w = MAX_COLS;
		return w;
	endfunction

	function automatic int grid_height();
		int h;
		h = int'(rows_reg);
		if (h < 1) h = 1;
		if (h > MAX_ROWS) h = MAX_ROWS;
		return h;
	endfunction

	// bottom row scroll rotates the offset and blanks the new bottom row
	function automatic logic line_feed(int h);
		int p;
		if (cur_row + 1 >= h) begin
			top_off = (top_off + 1) % MAX_ROWS;
			cur_row = h - 1;
			p = (top_off + h - 1) % MAX_ROWS;
			for (int c = 0; c < MAX_COLS; c++) cells[p*MAX_COLS + c] = '0;
			return 1'b1;
		end
		cur_row = cur_row + 1;
		return 1'b0;
	endfunction

	function automatic screen_result_t apply_action(logic [ACT_W-1:0] act,
			logic [CODE_W-1:0] code, logic [COL_W-1:0] tcol, logic [ROW_W-1:0] trow);
		int             w;
		int             h;
		int             r;
		screen_result_t res;
		w = grid_width();
		h = grid_height();
		res = '0;
		// grid may have shrunk under the cursor
		if (cur_row > h - 1) cur_row = h - 1;
		if (cur_col > w) cur_col = w;
		case (act)
			ACT_PUT: begin
				if (cur_col >= w) begin
					cur_col = 0;
					res.scrolled = line_feed(h);
				end
				cells[((top_off + cur_row) % MAX_ROWS)*MAX_COLS + cur_col] = code;
				cur_col = cur_col + 1;
			end
			ACT_CR: cur_col = 0;
			ACT_LF: res.scrolled = line_feed(h);
			ACT_MOVE: begin
				cur_row = (int'(trow) > h - 1) ? h - 1 : int'(trow);
				cur_col = (int'(tcol) > w) ? w : int'(tcol);
			end
			ACT_READ: begin
				r = (int'(trow) > h - 1) ? h - 1 : int'(trow);
				if (int'(tcol) < w)
					res.cell_char = cells[((top_off + r) % MAX_ROWS)*MAX_COLS + int'(tcol)];
			end
			default: ;
		endcase
		res.cursor_col = COL_W'(cur_col);
		res.cursor_row = ROW_W'(cur_row);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		screen_result_t got;
		screen_result_t want;
		int             bad;
		if (!arst_n) begin
			for (int i = 0; i < MAX_COLS*MAX_ROWS; i++) cells[i] = '0;
			cols_reg = COLS_RESET;
			rows_reg = ROWS_RESET;
			top_off = 0;
			cur_col = 0;
			cur_row = int'(ROWS_RESET) - 1;
			owed_q.delete();
			results_owed <= 0;
			mismatches <= 0;
		end else begin
			bad = 0;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_COLS: cols_reg = cfg.data[CFG_COLS_W-1:0];
					CFG_ROWS: rows_reg = cfg.data[CFG_ROWS_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				owed_q.push_back(apply_action(in_ch.action, in_ch.char_code,
					in_ch.target_col, in_ch.target_row));
			if (out_ch.valid && out_ch.ready) begin
				got.cell_char  = out_ch.cell_char;
				got.cursor_col = out_ch.cursor_col;
				got.cursor_row = out_ch.cursor_row;
				got.scrolled   = out_ch.scrolled;
				if (owed_q.size() == 0) begin
					$display("%0t: unexpected result item char=%0h col=%0d row=%0d",
						$time, got.cell_char, got.cursor_col, got.cursor_row,
						" scrolled=%0b", got.scrolled);
					bad = 1;
				end else begin
					want = owed_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected char=%0h col=%0d row=%0d",
							$time, want.cell_char, want.cursor_col, want.cursor_row,
							" scrolled=%0b, actual char=%0h col=%0d row=%0d scrolled=%0b",
							want.scrolled, got.cell_char, got.cursor_col,
							got.cursor_row, got.scrolled);
						bad = 1;
					end
				end
			end
			mismatches <= mismatches + bad;
			results_owed <= owed_q.size();
		end
	end

endmodule

@@ test/tb_text_grid_cursor_scroll.sv @@
// top of the text grid block regression: stimulus, receiver stalls and verdict
module tb_text_grid_cursor_scroll;
	import tgcs_pkg::*;

	logic clk;
	logic arst_n;
	logic hold_req;
	int   results_owed;
	int   mismatches;
	int   width_now;
	int   height_now;

	tgcs_in_if  in_ch ();
	tgcs_out_if out_ch ();
	tgcs_cfg_if cfg ();

	text_grid_cursor_scroll DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	tgcs_result_checker u_result_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.cfg          (cfg),
		.results_owed (results_owed),
		.mismatches   (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [CODE_W-1:0] code,
			input logic [COL_W-1:0] tcol, input logic [ROW_W-1:0] trow);
		in_ch.valid      <= 1'b1;
		in_ch.action     <= act;
		in_ch.char_code  <= code;
		in_ch.target_col <= tcol;
		in_ch.target_row <= trow;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			in_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		if (idx == CFG_COLS)
			width_now = (data == 0) ? 1 : (int'(data) > MAX_COLS) ? MAX_COLS : int'(data);
		else if (idx == CFG_ROWS)
			height_now = (data[CFG_ROWS_W-1:0] == 0) ? 1 :
				(int'(data[CFG_ROWS_W-1:0]) > MAX_ROWS) ? MAX_ROWS : int'(data[CFG_ROWS_W-1:0]);
	endtask

	task automatic set_grid(input int cols, input int rows);
		wait_drain();
		repeat (3) @(posedge clk);
		write_reg(CFG_COLS, CFG_DATA_W'(cols));
		write_reg(CFG_ROWS, CFG_DATA_W'(rows));
	endtask

	// mostly text with cursor motion, reads near the active grid, a few odd codes
	task automatic send_random(input int count, input int max_gap);
		int                burst;
		int                sel;
		logic [ACT_W-1:0]  act;
		logic [COL_W-1:0]  tcol;
		logic [ROW_W-1:0]  trow;
		burst = 0;
		repeat (count) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				if (max_gap > 0) pause_sender($urandom_range(0, max_gap));
			end
			sel = $urandom_range(0, 99);
			if (sel < 50) act = ACT_PUT;
			else if (sel < 58) act = ACT_CR;
			else if (sel < 68) act = ACT_LF;
			else if (sel < 80) act = ACT_MOVE;
			else if (sel < 97) act = ACT_READ;
			else act = ACT_W'($urandom_range(int'(ACT_READ) + 1, (1 << ACT_W) - 1));
			tcol = ($urandom_range(0, 7) == 0) ? COL_W'($urandom) :
				COL_W'($urandom_range(0, width_now + 1));
			trow = ($urandom_range(0, 7) == 0) ? ROW_W'($urandom) :
				ROW_W'($urandom_range(0, height_now - 1));
			send_item(act, CODE_W'($urandom), tcol, trow);
			burst = burst - 1;
		end
	endtask

	initial begin
		int mode;
		int span;
		int period;
		int duty;
		forever begin
			mode   = $urandom_range(0, 3);
			span   = $urandom_range(16, 160);
			period = $urandom_range(2, 9);
			duty   = $urandom_range(1, period - 1);
			for (int tick = 0; tick < span; tick++) begin
				if (hold_req) begin
					hold_req = 1'b0;
					out_ch.ready <= 1'b0;
					repeat (400) @(posedge clk);
				end else begin
					case (mode)
						0: out_ch.ready <= 1'b1;
						1: out_ch.ready <= 1'($urandom_range(0, 1));
						2: out_ch.ready <= ($urandom_range(0, 9) != 0);
						default: out_ch.ready <= ((tick % period) < duty);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		in_ch.valid      <= 1'b0;
		in_ch.action     <= ACT_PUT;
		in_ch.char_code  <= '0;
		in_ch.target_col <= '0;
		in_ch.target_row <= '0;
		cfg.valid        <= 1'b0;
		cfg.index        <= CFG_COLS;
		cfg.data         <= '0;
		arst_n           <= 1'b0;
		hold_req         = 1'b0;
		width_now        = int'(COLS_RESET);
		height_now       = int'(ROWS_RESET);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset grid, edges of the fields, scroll, wrap and clamps
		send_item(ACT_READ, '0, '0, '0);
		send_item(ACT_READ, '0, '1, '1);
		send_item(ACT_PUT, '0, '0, '0);
		send_item(ACT_PUT, '1, '0, '0);
		send_item(ACT_READ, '0, COL_W'(1), ROW_W'(int'(ROWS_RESET) - 1));
		send_item(ACT_CR, '0, '0, '0);
		send_item(ACT_LF, '0, '0, '0);
		send_item(ACT_READ, '0, COL_W'(1), ROW_W'(int'(ROWS_RESET) - 2));
		send_item(ACT_MOVE, '0, COL_W'(MAX_COLS), '1);
		send_item(ACT_PUT, CODE_W'(8'h41), '0, '0);
		send_item(ACT_MOVE, '0, '0, '0);
		send_item(ACT_LF, '0, '0, '0);
		for (int a = int'(ACT_READ) + 1; a < (1 << ACT_W); a++)
			send_item(ACT_W'(a), '1, '1, '1);
		set_grid(1, 1);
		send_item(ACT_PUT, CODE_W'(8'h5a), '0, '0);
		send_item(ACT_PUT, CODE_W'(8'ha5), '0, '0);
		send_item(ACT_READ, '0, '0, '0);
		send_item(ACT_LF, '0, '0, '0);
		set_grid(MAX_COLS, MAX_ROWS);
		send_item(ACT_MOVE, '0, COL_W'(MAX_COLS), '1);
		send_item(ACT_PUT, CODE_W'(8'h80), '0, '0);
		send_item(ACT_READ, '0, '0, '1);
		send_item(ACT_MOVE, '0, COL_W'(MAX_COLS), '1);
		set_grid(3, 2);
		write_reg(CFG_IDX_W'(int'(CFG_ROWS) + 1), '1);
		write_reg('1, '1);
		send_item(ACT_READ, '0, '0, '0);

		for (int phase = 0; phase < 14; phase++) begin
			case (phase)
				0: set_grid(1, 1);
				1: set_grid(MAX_COLS, MAX_ROWS);
				2: set_grid(0, 0);
				3: set_grid(255, 255);
				4: set_grid(MAX_COLS, 1);
				5: set_grid(1, MAX_ROWS);
				6, 10: set_grid($urandom_range(1, MAX_COLS), $urandom_range(1, MAX_ROWS));
				default: set_grid($urandom_range(2, 16), $urandom_range(1, 8));
			endcase
			if (phase == 3) begin
				hold_req = 1'b1;
				send_random(60, 0);
				send_random(50, 12);
			end else if (phase == 5) begin
				send_random(55, 12);
				wait_drain();
				send_random(55, 12);
			end else begin
				send_random(110, (phase % 3 == 0) ? 0 : 12);
			end
		end

		wait_drain();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
